// ===== rtl/battery_level_monitor_assert.svh =====
// Assertion macros used by the battery level monitor checker
`ifndef BATTERY_LEVEL_MONITOR_ASSERT_SVH
`define BATTERY_LEVEL_MONITOR_ASSERT_SVH

// Same-cycle implication, masked during reset
`define BLM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked during reset
`define BLM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked through reset
`define BLM_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/blm_pkg.sv =====
// Package: types, register indexes, reset values and codes of the battery level monitor
package blm_pkg;

  localparam int unsigned FRACTION_BITS_DEF = 8;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HYST     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR    = 3'd4;

  localparam logic [15:0] CRITICAL_RST = 16'd3300;
  localparam logic [15:0] LOW_RST      = 16'd3500;
  localparam logic [11:0] HYST_RST     = 12'd50;
  localparam logic [8:0]  WEIGHT_RST   = 9'd230;
  localparam logic [15:0] FLOOR_RST    = 16'd2500;

  localparam logic [8:0] WEIGHT_FULL = 9'd256;

  typedef enum logic [1:0] {
    LVL_NORMAL   = 2'd0,
    LVL_LOW      = 2'd1,
    LVL_CRITICAL = 2'd2
  } lvl_t;

  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_PRESENT = 2'd1;
  localparam logic [1:0] EV_REMOVED = 2'd2;

endpackage

// ===== rtl/battery_level_monitor.sv =====
// Battery level monitor: three-stage pipeline with smoothing filter and level machine
// One word is accepted per cycle while in_ready is high; each word passes through the
// input register, the smoothed-voltage register and the result register. The smoothing
// filter closes its loop through a single 10 x (17+FRACTION_BITS) bit multiply-add on
// the smoothed-voltage register, and the level machine closes its loop through the
// level register one stage later. Stalls are absorbed stage by stage, so bubbles are
// filled while a finished result waits. Configuration writes are registered; the
// user must make them only while the pipeline holds no words; the block does not enforce it.
module battery_level_monitor
  import blm_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [15:0]           in_sample_mv,
  input  logic                  in_charging,
  input  logic                  in_battery_present,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [15:0]           out_smoothed_mv,
  output logic [1:0]            out_level,
  output logic                  out_level_changed,
  output logic [1:0]            out_prior_level,
  output logic                  out_ready_flag,
  output logic [1:0]            out_presence_event
);

  localparam int unsigned SW = 16 + FRACTION_BITS;
  localparam int unsigned PW = SW + 11;

  logic [15:0] crit_r, low_r, floor_r;
  logic [11:0] hyst_r;
  logic [8:0]  weight_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crit_r   <= CRITICAL_RST;
      low_r    <= LOW_RST;
      hyst_r   <= HYST_RST;
      weight_r <= WEIGHT_RST;
      floor_r  <= FLOOR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CRITICAL: crit_r   <= cfg_wdata;
        CFG_LOW:      low_r    <= cfg_wdata;
        CFG_HYST:     hyst_r   <= cfg_wdata[11:0];
        CFG_WEIGHT:   weight_r <= cfg_wdata[8:0];
        CFG_FLOOR:    floor_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Stage handshake
  logic s1_v_r, s2_v_r, out_v_r;
  logic adv1, adv2, adv3;

  assign adv3     = !out_v_r || out_ready;
  assign adv2     = !s2_v_r || adv3;
  assign adv1     = !s1_v_r || adv2;
  assign in_ready = adv1;

  // Input register
  logic [15:0] s1_sample_r;
  logic        s1_chg_r, s1_pres_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv1) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      s1_sample_r <= in_sample_mv;
      s1_chg_r    <= in_charging;
      s1_pres_r   <= in_battery_present;
    end
  end

  // Smoothing filter: new = scaled + floor(w * (old - scaled) / 256), or scaled if old < floor
  logic [SW-1:0]        sm_r, sm_nxt, scaled, floor_sc;
  logic [8:0]           w_sat;
  logic signed [SW:0]   diff;
  logic signed [PW-1:0] prod, sum;
  logic                 s2_chg_r, s2_pres_r;

  always_comb begin
    scaled   = SW'(s1_sample_r) << FRACTION_BITS;
    floor_sc = SW'(floor_r) << FRACTION_BITS;
    w_sat    = (weight_r > WEIGHT_FULL) ? WEIGHT_FULL : weight_r;
    diff     = $signed({1'b0, sm_r}) - $signed({1'b0, scaled});
    prod     = $signed({1'b0, w_sat}) * diff;
    sum      = $signed({{11{1'b0}}, scaled}) + (prod >>> 8);
    sm_nxt   = (sm_r < floor_sc) ? scaled : sum[SW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      sm_r   <= '0;
    end else if (adv2) begin
      s2_v_r <= s1_v_r;
      if (s1_v_r) begin
        sm_r <= sm_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && s1_v_r) begin
      s2_chg_r  <= s1_chg_r;
      s2_pres_r <= s1_pres_r;
    end
  end

  // Level machine
  lvl_t               lvl_r, lvl_nxt;
  logic [15:0]        v;
  logic signed [17:0] v_s, crit_lo, crit_hi, low_lo, low_hi;
  logic               lvl_en;

  assign lvl_en = adv3 && s2_v_r;

  always_comb begin
    v       = sm_r[SW-1:FRACTION_BITS];
    v_s     = $signed({2'b00, v});
    crit_lo = $signed({2'b00, crit_r}) - $signed({6'b0, hyst_r});
    crit_hi = $signed({2'b00, crit_r}) + $signed({6'b0, hyst_r});
    low_lo  = $signed({2'b00, low_r}) - $signed({6'b0, hyst_r});
    low_hi  = $signed({2'b00, low_r}) + $signed({6'b0, hyst_r});
    lvl_nxt = lvl_r;
    if (s2_chg_r) begin
      lvl_nxt = LVL_NORMAL;
    end else begin
      unique case (lvl_r)
        LVL_NORMAL: begin
          if (v_s < crit_lo)     lvl_nxt = LVL_CRITICAL;
          else if (v_s < low_lo) lvl_nxt = LVL_LOW;
        end
        LVL_LOW: begin
          if (v_s > low_hi)       lvl_nxt = LVL_NORMAL;
          else if (v_s < crit_lo) lvl_nxt = LVL_CRITICAL;
        end
        LVL_CRITICAL: begin
          if (v_s > low_hi)       lvl_nxt = LVL_NORMAL;
          else if (v_s > crit_hi) lvl_nxt = LVL_LOW;
        end
        default: lvl_nxt = lvl_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_r <= LVL_NORMAL;
    end else if (lvl_en) begin
      lvl_r <= lvl_nxt;
    end
  end

  // Result register
  logic        rdy_r, changed_r;
  logic [1:0]  prior_r, event_r, event_nxt;
  logic [15:0] out_sm_r;

  always_comb begin
    event_nxt = EV_NONE;
    if (!rdy_r && s2_pres_r)      event_nxt = EV_PRESENT;
    else if (rdy_r && !s2_pres_r) event_nxt = EV_REMOVED;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      rdy_r   <= 1'b0;
    end else if (adv3) begin
      out_v_r <= s2_v_r;
      if (s2_v_r) begin
        rdy_r <= s2_pres_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (lvl_en) begin
      prior_r   <= lvl_r;
      changed_r <= (lvl_nxt != lvl_r);
      out_sm_r  <= v;
      event_r   <= event_nxt;
    end
  end

  assign out_valid          = out_v_r;
  assign out_smoothed_mv    = out_sm_r;
  assign out_level          = lvl_r;
  assign out_level_changed  = changed_r;
  assign out_prior_level    = prior_r;
  assign out_ready_flag     = rdy_r;
  assign out_presence_event = event_r;

endmodule

// ===== rtl/blm_checker.sv =====
// Port-level assertion checker for the battery level monitor, with its bind
`include "battery_level_monitor_assert.svh"

module blm_checker
  import blm_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_smoothed_mv,
  input logic [1:0]  out_level,
  input logic        out_level_changed,
  input logic [1:0]  out_prior_level,
  input logic        out_ready_flag,
  input logic [1:0]  out_presence_event
);

  `BLM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_smoothed_mv) && $stable(out_level) && $stable(out_presence_event), "result word changed while stalled")

  `BLM_ASSERT_NOW(a_changed_flag, clk, rst_n, out_valid, out_level_changed == (out_level != out_prior_level), "level_changed disagrees with level and prior_level")

  `BLM_ASSERT_NOW(a_event_flag, clk, rst_n, out_valid, (out_presence_event != EV_PRESENT || out_ready_flag) && (out_presence_event != EV_REMOVED || !out_ready_flag), "presence event disagrees with ready flag")

  `BLM_ASSERT_ALWAYS(a_rst_idle, clk, !rst_n, !out_valid, "result valid right after reset")

endmodule

bind battery_level_monitor blm_checker u_blm_checker (.*);
